// ===== rtl/ptpg_pkg.sv =====
// ----------------------------------------------------------------------------
// ptpg_pkg: shared types and constants of the texture pixel generator
// Coordinate and fraction widths, pattern codes, register indexes and the
// sky colour table in Q8.16.
// ----------------------------------------------------------------------------
package ptpg_pkg;

  localparam int MAX_SIDE   = 4096;
  localparam int TILE_SIZE  = 8;
  localparam int COORD_W    = $clog2(MAX_SIDE);
  localparam int TILE_SHIFT = $clog2(TILE_SIZE);

  localparam int HEIGHT_W  = 13;
  localparam int PAT_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CHAN_W    = 8;

  localparam int FRAC_W = 16;
  localparam int ONE_Q  = 1 << FRAC_W;

  // row divider
  localparam int QUO_W = FRAC_W + 2;
  localparam int NUM_W = COORD_W + QUO_W;
  localparam int DIV_W = NUM_W + 1;
  localparam int T_W   = FRAC_W + 2;

  // square root and blend
  localparam int W_W        = FRAC_W + 1;
  localparam int ROOT_STEPS = FRAC_W + 1;
  localparam int RAD_W      = 2 * FRAC_W + 1;
  localparam int RES_W      = RAD_W + 1;
  localparam int COLOR_W    = 24;
  localparam int PROD_W     = COLOR_W + W_W;
  localparam int SUM_W      = PROD_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd1;

  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd8;

  typedef enum logic [PAT_W-1:0] {
    PAT_CHECKER = 2'd0,
    PAT_WHITE   = 2'd1,
    PAT_NORMAL  = 2'd2,
    PAT_SKY     = 2'd3
  } pattern_e;

  typedef struct packed {
    logic valid;
    logic odd;
  } side_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

  localparam logic [COLOR_W-1:0] ZENITH_Q [3] = '{24'd13369344, 24'd12533760, 24'd14204928};
  localparam logic [COLOR_W-1:0] HORIZON_Q [3] = '{24'd13369344, 24'd9191424, 24'd6684672};
  localparam logic [COLOR_W-1:0] GROUND_Q [3] = '{24'd1671168, 24'd1504051, 24'd1336934};

endpackage

// ===== rtl/procedural_texture_pixel_generator_unit.sv =====
// ----------------------------------------------------------------------------
// procedural_texture_pixel_generator_unit: RGBA8 pattern pixel generator
// Each input item is a pixel coordinate (col_i, row_i); each output item is
// its colour. Alpha is always 255.
//
// Input channel: in_valid_i / in_stall_o, accepted when valid and not stall.
// Output channel: out_valid_o / out_stall_i, taken when valid and not stall.
// Config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// index 0 selects the pattern, index 1 the image height, others are ignored.
// Ready is always high; write only while no item is in flight.
//
// Items pass through the row divider (one quotient bit per stage), the
// square root (one root step per stage), the blend registers and the output
// register. Throughput is one item per cycle while in_stall_o is low.
// A stalled result sits in the output register and one more in a skid
// register; the pipeline freezes and in_stall_o rises only once both are
// full. Reset empties the pipeline and sets pattern 0 and height 8.
// ----------------------------------------------------------------------------
module procedural_texture_pixel_generator_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [ptpg_pkg::COORD_W-1:0]          col_i,
  input  logic [ptpg_pkg::COORD_W-1:0]          row_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [ptpg_pkg::CHAN_W-1:0]           red_o,
  output logic [ptpg_pkg::CHAN_W-1:0]           green_o,
  output logic [ptpg_pkg::CHAN_W-1:0]           blue_o,
  output logic [ptpg_pkg::CHAN_W-1:0]           alpha_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ptpg_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [ptpg_pkg::HEIGHT_W-1:0]         cfg_data_i
);

  logic [ptpg_pkg::PAT_W-1:0]          pattern_q;
  logic [ptpg_pkg::HEIGHT_W-1:0]       height_q;

  logic                                en;
  ptpg_pkg::side_t                     side_in;
  logic [ptpg_pkg::COORD_W-1:0]        col_tile;
  logic [ptpg_pkg::COORD_W-1:0]        row_tile;

  ptpg_pkg::side_t                     div_side;
  logic signed [ptpg_pkg::T_W-1:0]     div_t;
  ptpg_pkg::side_t                     root_side;
  logic [ptpg_pkg::W_W-1:0]            root_w;
  logic                                root_zen;

  logic [ptpg_pkg::W_W-1:0]            inv_w;
  ptpg_pkg::side_t                     mul_side_q;
  logic [ptpg_pkg::PROD_W-1:0]         ph_q [3];
  logic [ptpg_pkg::PROD_W-1:0]         pt_q [3];
  ptpg_pkg::side_t                     chan_side_q;
  logic [ptpg_pkg::CHAN_W-1:0]         chan_d [3];
  logic [ptpg_pkg::CHAN_W-1:0]         chan_q [3];

  logic                                push;
  logic                                take;
  ptpg_pkg::pix_t                      push_pix;
  logic                                out_valid_d;
  logic                                out_valid_q;
  logic                                skid_valid_d;
  logic                                skid_valid_q;
  ptpg_pkg::pix_t                      out_pix_q;
  ptpg_pkg::pix_t                      skid_pix_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= ptpg_pkg::PAT_W'(ptpg_pkg::PAT_CHECKER);
      height_q  <= ptpg_pkg::HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == ptpg_pkg::CFG_PATTERN) begin
        pattern_q <= cfg_data_i[ptpg_pkg::PAT_W-1:0];
      end else if (cfg_index_i == ptpg_pkg::CFG_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  // pipeline moves while the skid register is free
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  assign col_tile      = col_i >> ptpg_pkg::TILE_SHIFT;
  assign row_tile      = row_i >> ptpg_pkg::TILE_SHIFT;
  assign side_in.valid = in_valid_i;
  assign side_in.odd   = col_tile[0] ^ row_tile[0];

  ptpg_tdiv u_tdiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .side_i   (side_in),
    .row_i    (row_i),
    .height_i (height_q),
    .side_o   (div_side),
    .t_o      (div_t)
  );

  ptpg_wsqrt u_wsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (div_side),
    .t_i    (div_t),
    .side_o (root_side),
    .w_o    (root_w),
    .zen_o  (root_zen)
  );

  // blend: products, then round and saturate
  assign inv_w = ptpg_pkg::W_W'(ptpg_pkg::ONE_Q) - root_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_side_q  <= '0;
      chan_side_q <= '0;
    end else if (en) begin
      mul_side_q  <= root_side;
      chan_side_q <= mul_side_q;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [ptpg_pkg::SUM_W-1:0]                 sum;
    logic [ptpg_pkg::SUM_W-ptpg_pkg::FRAC_W:0]  rnd;
    logic [ptpg_pkg::SUM_W-ptpg_pkg::FRAC_W:0]  whole;

    assign sum   = {1'b0, ph_q[c]} + {1'b0, pt_q[c]};
    assign rnd   = (ptpg_pkg::SUM_W - ptpg_pkg::FRAC_W + 1)'(sum >> ptpg_pkg::FRAC_W)
                 + (ptpg_pkg::SUM_W - ptpg_pkg::FRAC_W + 1)'(ptpg_pkg::ONE_Q / 2);
    assign whole = rnd >> ptpg_pkg::FRAC_W;
    assign chan_d[c] = (whole > (ptpg_pkg::SUM_W - ptpg_pkg::FRAC_W + 1)'(255))
                     ? {ptpg_pkg::CHAN_W{1'b1}} : whole[ptpg_pkg::CHAN_W-1:0];

    always_ff @(posedge clk_i) begin
      if (en) begin
        ph_q[c] <= ptpg_pkg::PROD_W'(ptpg_pkg::HORIZON_Q[c]) * ptpg_pkg::PROD_W'(inv_w);
        if (root_zen) begin
          pt_q[c] <= ptpg_pkg::PROD_W'(ptpg_pkg::ZENITH_Q[c]) * ptpg_pkg::PROD_W'(root_w);
        end else begin
          pt_q[c] <= ptpg_pkg::PROD_W'(ptpg_pkg::GROUND_Q[c]) * ptpg_pkg::PROD_W'(root_w);
        end
        chan_q[c] <= chan_d[c];
      end
    end
  end

  // pattern select
  always_comb begin
    unique case (ptpg_pkg::pattern_e'(pattern_q))
      ptpg_pkg::PAT_CHECKER: begin
        push_pix.red   = 8'hFF;
        push_pix.green = chan_side_q.odd ? 8'hFF : 8'h00;
        push_pix.blue  = 8'hFF;
      end
      ptpg_pkg::PAT_WHITE: begin
        push_pix.red   = 8'hFF;
        push_pix.green = 8'hFF;
        push_pix.blue  = 8'hFF;
      end
      ptpg_pkg::PAT_NORMAL: begin
        push_pix.red   = 8'h80;
        push_pix.green = 8'h80;
        push_pix.blue  = 8'hFF;
      end
      ptpg_pkg::PAT_SKY: begin
        push_pix.red   = chan_q[0];
        push_pix.green = chan_q[1];
        push_pix.blue  = chan_q[2];
      end
      default: begin
        push_pix = '0;
      end
    endcase
  end

  // output register plus skid
  assign push = en && chan_side_q.valid;
  assign take = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || take) begin
      out_valid_d  = skid_valid_q || push;
      skid_valid_d = 1'b0;
    end else if (push) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      out_pix_q <= skid_valid_q ? skid_pix_q : push_pix;
    end else if (push) begin
      skid_pix_q <= push_pix;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = out_pix_q.red;
  assign green_o     = out_pix_q.green;
  assign blue_o      = out_pix_q.blue;
  assign alpha_o     = {ptpg_pkg::CHAN_W{1'b1}};

endmodule

// ===== rtl/ptpg_tdiv.sv =====
// ----------------------------------------------------------------------------
// ptpg_tdiv: pipelined row-to-gradient divider
// Forms t = round(2*row/(height-1)) - 1 in signed Q1.16, one quotient bit per
// stage, saturated at +1 and forced to -1 for a single-row image.
// ----------------------------------------------------------------------------
module ptpg_tdiv (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  ptpg_pkg::side_t                      side_i,
  input  logic [ptpg_pkg::COORD_W-1:0]         row_i,
  input  logic [ptpg_pkg::HEIGHT_W-1:0]        height_i,
  output ptpg_pkg::side_t                      side_o,
  output logic signed [ptpg_pkg::T_W-1:0]      t_o
);

  localparam int NS = ptpg_pkg::QUO_W + 1;

  logic                                one_row;
  logic [ptpg_pkg::HEIGHT_W-1:0]       div_d;
  logic [ptpg_pkg::NUM_W-1:0]          num_d;
  logic                                sat_d;

  ptpg_pkg::side_t                     side_q [NS];
  logic [ptpg_pkg::NUM_W-1:0]          rem_q  [NS];
  logic [ptpg_pkg::QUO_W-1:0]          quo_q  [NS];
  logic                                sat_q  [NS];

  ptpg_pkg::side_t                     out_side_q;
  logic [ptpg_pkg::QUO_W-1:0]          quo_lim;
  logic signed [ptpg_pkg::T_W-1:0]     t_d;
  logic signed [ptpg_pkg::T_W-1:0]     t_q;

  assign one_row = (height_i <= ptpg_pkg::HEIGHT_W'(1));
  assign div_d   = height_i - ptpg_pkg::HEIGHT_W'(1);

  // numerator 2*row*one plus half the divisor for rounding
  assign num_d = ptpg_pkg::NUM_W'({row_i, {(ptpg_pkg::FRAC_W + 1){1'b0}}})
               + ptpg_pkg::NUM_W'(div_d >> 1);
  assign sat_d = ptpg_pkg::HEIGHT_W'(num_d >> ptpg_pkg::QUO_W) >= div_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q[0] <= '0;
    end else if (en_i) begin
      side_q[0] <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_d;
      quo_q[0] <= '0;
      sat_q[0] <= sat_d;
    end
  end

  for (genvar i = 1; i < NS; i++) begin : g_bit
    localparam int K = ptpg_pkg::QUO_W - i;
    logic [ptpg_pkg::DIV_W-1:0] divisor;
    logic                       take;

    assign divisor = ptpg_pkg::DIV_W'(div_d) << K;
    assign take    = !sat_q[i-1] && ({1'b0, rem_q[i-1]} >= divisor);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[i] <= '0;
      end else if (en_i) begin
        side_q[i] <= side_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sat_q[i] <= sat_q[i-1];
        if (take) begin
          rem_q[i] <= rem_q[i-1] - ptpg_pkg::NUM_W'(divisor);
        end else begin
          rem_q[i] <= rem_q[i-1];
        end
        quo_q[i] <= quo_q[i-1] | (ptpg_pkg::QUO_W'(take) << K);
      end
    end
  end

  // clamp t at +1, or force t to -1 for a single-row image
  always_comb begin
    if (sat_q[NS-1] || (quo_q[NS-1] > ptpg_pkg::QUO_W'(2 * ptpg_pkg::ONE_Q))) begin
      quo_lim = ptpg_pkg::QUO_W'(2 * ptpg_pkg::ONE_Q);
    end else begin
      quo_lim = quo_q[NS-1];
    end
    if (one_row) begin
      t_d = ptpg_pkg::T_W'(-ptpg_pkg::ONE_Q);
    end else begin
      t_d = ptpg_pkg::T_W'(quo_lim) - ptpg_pkg::T_W'(ptpg_pkg::ONE_Q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_side_q <= '0;
    end else if (en_i) begin
      out_side_q <= side_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q <= t_d;
    end
  end

  assign side_o = out_side_q;
  assign t_o    = t_q;

endmodule

// ===== rtl/ptpg_wsqrt.sv =====
// ----------------------------------------------------------------------------
// ptpg_wsqrt: pipelined blend weight unit
// Above the horizon the weight is the floor square root of -t in Q1.16, one
// root step per stage; below it the weight is min(2t, 1).
// ----------------------------------------------------------------------------
module ptpg_wsqrt (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  ptpg_pkg::side_t                      side_i,
  input  logic signed [ptpg_pkg::T_W-1:0]      t_i,
  output ptpg_pkg::side_t                      side_o,
  output logic [ptpg_pkg::W_W-1:0]             w_o,
  output logic                                 zen_o
);

  localparam int NS = ptpg_pkg::ROOT_STEPS + 1;

  logic                                nonpos;
  logic [ptpg_pkg::T_W-1:0]            mag;
  logic [ptpg_pkg::T_W-1:0]            dbl;
  logic [ptpg_pkg::W_W-1:0]            wpos_d;

  ptpg_pkg::side_t                     side_q [NS];
  logic [ptpg_pkg::RAD_W-1:0]          rad_q  [NS];
  logic [ptpg_pkg::RES_W-1:0]          res_q  [NS];
  logic                                zen_q  [NS];
  logic [ptpg_pkg::W_W-1:0]            wpos_q [NS];

  ptpg_pkg::side_t                     out_side_q;
  logic [ptpg_pkg::W_W-1:0]            w_d;
  logic [ptpg_pkg::W_W-1:0]            w_q;
  logic                                out_zen_q;

  assign nonpos = t_i[ptpg_pkg::T_W-1] || (t_i == '0);
  assign mag    = nonpos ? ptpg_pkg::T_W'(-t_i) : ptpg_pkg::T_W'(t_i);
  assign dbl    = {mag[ptpg_pkg::T_W-2:0], 1'b0};
  assign wpos_d = (dbl > ptpg_pkg::T_W'(ptpg_pkg::ONE_Q))
                ? ptpg_pkg::W_W'(ptpg_pkg::ONE_Q) : dbl[ptpg_pkg::W_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q[0] <= '0;
    end else if (en_i) begin
      side_q[0] <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q[0]  <= ptpg_pkg::RAD_W'({mag[ptpg_pkg::W_W-1:0], {ptpg_pkg::FRAC_W{1'b0}}});
      res_q[0]  <= '0;
      zen_q[0]  <= nonpos;
      wpos_q[0] <= wpos_d;
    end
  end

  for (genvar j = 1; j < NS; j++) begin : g_root
    localparam int SH = 2 * (ptpg_pkg::ROOT_STEPS - j);
    logic [ptpg_pkg::RES_W-1:0] bitv;
    logic [ptpg_pkg::RES_W:0]   trial;
    logic                       take;

    assign bitv  = ptpg_pkg::RES_W'(1) << SH;
    assign trial = {1'b0, res_q[j-1]} + {1'b0, bitv};
    assign take  = (ptpg_pkg::RES_W'(rad_q[j-1]) >= ptpg_pkg::RES_W'(trial))
                && !trial[ptpg_pkg::RES_W] && (trial[ptpg_pkg::RES_W-1:ptpg_pkg::RAD_W] == '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[j] <= '0;
      end else if (en_i) begin
        side_q[j] <= side_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zen_q[j]  <= zen_q[j-1];
        wpos_q[j] <= wpos_q[j-1];
        if (take) begin
          rad_q[j] <= rad_q[j-1] - ptpg_pkg::RAD_W'(trial);
          res_q[j] <= (res_q[j-1] >> 1) + bitv;
        end else begin
          rad_q[j] <= rad_q[j-1];
          res_q[j] <= res_q[j-1] >> 1;
        end
      end
    end
  end

  always_comb begin
    if (!zen_q[NS-1]) begin
      w_d = wpos_q[NS-1];
    end else if (res_q[NS-1] > ptpg_pkg::RES_W'(ptpg_pkg::ONE_Q)) begin
      w_d = ptpg_pkg::W_W'(ptpg_pkg::ONE_Q);
    end else begin
      w_d = res_q[NS-1][ptpg_pkg::W_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_side_q <= '0;
    end else if (en_i) begin
      out_side_q <= side_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q       <= w_d;
      out_zen_q <= zen_q[NS-1];
    end
  end

  assign side_o = out_side_q;
  assign w_o    = w_q;
  assign zen_o  = out_zen_q;

endmodule
